@@ rtl/lrg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrg_pkg: shared types and constants of the Laplace relaxation grid
// Command codes, configuration register indexes, fixed port widths and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lrg_pkg;

  localparam int CMD_W      = 2;
  localparam int IN_IDX_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_W      = 5;
  localparam int SWEEP_W    = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS     = 3'd0,
    CFG_COLS     = 3'd1,
    CFG_SWEEPS   = 3'd2,
    CFG_TOP      = 3'd3,
    CFG_OTHER    = 3'd4,
    CFG_INTERIOR = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic ld_read;
    logic init_start;
    logic run_start;
    logic init_write;
    logic rd_ud;
    logic rd_lr;
    logic run_write;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic init_done;
    logic cell_last;
    logic sweep_last;
    logic sweeps_zero;
    logic out_free;
  } dp_sts_t;

endpackage

@@ rtl/lrg_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrg_ram: generic RAM, one write port and two registered read ports
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module lrg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/lrg_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrg_datapath: registers, grid memory, counters and relaxation arithmetic
// Holds configuration, walks the grid under controller commands and keeps
// the output register.
// ----------------------------------------------------------------------------
module lrg_datapath #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLS    = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lrg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lrg_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [lrg_pkg::IN_IDX_W-1:0]        row_i,
  input  logic [lrg_pkg::IN_IDX_W-1:0]        col_i,
  input  lrg_pkg::dp_cmd_t                    cmd_i,
  output lrg_pkg::dp_sts_t                    sts_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [VALUE_WIDTH-1:0]              cell_value_o
);

  import lrg_pkg::*;

  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = VALUE_WIDTH + 2;

  logic [DIM_W-1:0]       rows_q, cols_q;
  logic [SWEEP_W-1:0]     sweeps_q;
  logic [VALUE_WIDTH-1:0] top_q, other_q, interior_q;

  logic [RIW-1:0]         row_q, last_r, inner_last_r;
  logic [CIW-1:0]         col_q, last_c, inner_last_c;
  logic [SWEEP_W-1:0]     sweep_q;
  logic                   oob_q;
  logic [VALUE_WIDTH:0]   sum_ud_q;
  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] cell_value_q;

  logic [AW-1:0]          center, up, down, left, right;
  logic [AW-1:0]          raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0] rdata_a, rdata_b;
  logic [VALUE_WIDTH-1:0] init_val, relaxed, wdata;
  logic [SW-1:0]          sum_all;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= DIM_W'(10);
      cols_q     <= DIM_W'(12);
      sweeps_q   <= SWEEP_W'(1);
      top_q      <= VALUE_WIDTH'(25600);
      other_q    <= '0;
      interior_q <= VALUE_WIDTH'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS:     rows_q     <= DIM_W'(cfg_wdata_i);
        CFG_COLS:     cols_q     <= DIM_W'(cfg_wdata_i);
        CFG_SWEEPS:   sweeps_q   <= SWEEP_W'(cfg_wdata_i);
        CFG_TOP:      top_q      <= VALUE_WIDTH'(cfg_wdata_i);
        CFG_OTHER:    other_q    <= VALUE_WIDTH'(cfg_wdata_i);
        CFG_INTERIOR: interior_q <= VALUE_WIDTH'(cfg_wdata_i);
        default: begin
        end
      endcase
    end
  end

  // clamp the dimensions in use to 3..MAX
  always_comb begin
    if (rows_q < DIM_W'(3)) begin
      last_r = RIW'(2);
    end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
      last_r = RIW'(MAX_ROWS - 1);
    end else begin
      last_r = RIW'(rows_q - DIM_W'(1));
    end
    if (cols_q < DIM_W'(3)) begin
      last_c = CIW'(2);
    end else if (32'(cols_q) > 32'(MAX_COLS)) begin
      last_c = CIW'(MAX_COLS - 1);
    end else begin
      last_c = CIW'(cols_q - DIM_W'(1));
    end
  end

  assign inner_last_r = last_r - RIW'(1);
  assign inner_last_c = last_c - CIW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      sweep_q <= '0;
      oob_q   <= 1'b0;
    end else if (cmd_i.ld_read) begin
      row_q <= RIW'(row_i);
      col_q <= CIW'(col_i);
      oob_q <= (32'(row_i) >= 32'(MAX_ROWS)) || (32'(col_i) >= 32'(MAX_COLS));
    end else if (cmd_i.init_start) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.run_start) begin
      row_q   <= RIW'(1);
      col_q   <= CIW'(1);
      sweep_q <= SWEEP_W'(1);
    end else if (cmd_i.init_write) begin
      if (col_q == last_c) begin
        col_q <= '0;
        row_q <= row_q + RIW'(1);
      end else begin
        col_q <= col_q + CIW'(1);
      end
    end else if (cmd_i.run_write) begin
      if (col_q == inner_last_c) begin
        col_q <= CIW'(1);
        if (row_q == inner_last_r) begin
          row_q   <= RIW'(1);
          sweep_q <= sweep_q + SWEEP_W'(1);
        end else begin
          row_q <= row_q + RIW'(1);
        end
      end else begin
        col_q <= col_q + CIW'(1);
      end
    end
  end

  assign center = AW'(row_q) * AW'(MAX_COLS) + AW'(col_q);
  assign up     = center - AW'(MAX_COLS);
  assign down   = center + AW'(MAX_COLS);
  assign left   = center - AW'(1);
  assign right  = center + AW'(1);

  always_comb begin
    if (cmd_i.rd_ud) begin
      raddr_a = up;
      raddr_b = down;
    end else if (cmd_i.rd_lr) begin
      raddr_a = left;
      raddr_b = right;
    end else begin
      raddr_a = center;
      raddr_b = right;
    end
  end

  always_comb begin
    if (row_q == '0) begin
      init_val = top_q;
    end else if (row_q == last_r || col_q == '0 || col_q == last_c) begin
      init_val = other_q;
    end else begin
      init_val = interior_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_lr) begin
      sum_ud_q <= {1'b0, rdata_a} + {1'b0, rdata_b};
    end
  end

  assign sum_all = SW'(sum_ud_q) + SW'(rdata_a) + SW'(rdata_b);
  assign relaxed = sum_all[SW-1:2];
  assign wdata   = cmd_i.init_write ? init_val : relaxed;

  lrg_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CELLS)
  ) u_grid (
    .clk_i     (clk_i),
    .we_i      (cmd_i.init_write | cmd_i.run_write),
    .waddr_i   (center),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cell_value_q <= oob_q ? '0 : rdata_a;
    end
  end

  assign sts_o.init_done   = (row_q == last_r) && (col_q == last_c);
  assign sts_o.cell_last   = (row_q == inner_last_r) && (col_q == inner_last_c);
  assign sts_o.sweep_last  = (sweep_q == sweeps_q);
  assign sts_o.sweeps_zero = (sweeps_q == '0);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_value_q;

endmodule

@@ rtl/lrg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrg_ctrl: command sequencer of the Laplace relaxation grid
// Decodes accepted commands and steps the datapath through init fill,
// relaxation sweeps and cell reads.
// ----------------------------------------------------------------------------
module lrg_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lrg_pkg::CMD_W-1:0]  cmd_i,
  input  lrg_pkg::dp_sts_t           sts_i,
  output lrg_pkg::dp_cmd_t           cmd_o
);

  import lrg_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_INIT    = 7'b0000010,
    ST_RUN_A   = 7'b0000100,
    ST_RUN_B   = 7'b0001000,
    ST_RUN_W   = 7'b0010000,
    ST_RD_ISS  = 7'b0100000,
    ST_RD_WAIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_i)
            CMD_INIT: begin
              cmd_o.init_start = 1'b1;
              state_d          = ST_INIT;
            end
            CMD_RUN: begin
              if (!sts_i.sweeps_zero) begin
                cmd_o.run_start = 1'b1;
                state_d         = ST_RUN_A;
              end
            end
            CMD_READ: begin
              cmd_o.ld_read = 1'b1;
              state_d       = ST_RD_ISS;
            end
            default: begin
            end
          endcase
        end
      end
      ST_INIT: begin
        cmd_o.init_write = 1'b1;
        if (sts_i.init_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN_A: begin
        cmd_o.rd_ud = 1'b1;
        state_d     = ST_RUN_B;
      end
      ST_RUN_B: begin
        cmd_o.rd_lr = 1'b1;
        state_d     = ST_RUN_W;
      end
      ST_RUN_W: begin
        cmd_o.run_write = 1'b1;
        state_d = (sts_i.cell_last && sts_i.sweep_last) ? ST_IDLE : ST_RUN_A;
      end
      ST_RD_ISS: begin
        state_d = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/laplace_relaxation_grid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplace_relaxation_grid: 2-D Gauss-Seidel relaxation of Q8.8 potentials
// Keeps a grid of potentials, fills it with interior and edge values, runs
// in-place relaxation sweeps over the interior and returns single cells.
//
//   channel  signals                              direction
//   in       in_valid_i in_stall_o cmd_i row_i col_i   into the block
//   out      out_valid_o out_stall_i cell_value_o      out of the block
//   cfg      cfg_we_i cfg_idx_i cfg_wdata_i            into the block
//
// One command at a time. Init fills the grid with one cell write a
// cycle. Run steps each interior cell through RUN_A, RUN_B and RUN_W:
// each cell needs its four neighbors through the two read ports of the grid
// memory, then one write. Read waits in RD_WAIT for a free output register.
// Reset returns control and configuration to their defaults; the grid holds
// garbage until init.
// The output register lets the next command in while a result is stalled.
// ----------------------------------------------------------------------------
module laplace_relaxation_grid #(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLS    = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lrg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lrg_pkg::CMD_W-1:0]       cmd_i,
  input  logic [lrg_pkg::IN_IDX_W-1:0]    row_i,
  input  logic [lrg_pkg::IN_IDX_W-1:0]    col_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [VALUE_WIDTH-1:0]          cell_value_o
);

  import lrg_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  lrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  lrg_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_value_o (cell_value_o)
  );

endmodule
